// ===== hw/rtl/pbbc_pkg.sv =====
// shared types and constants for the periodic bond break check
`default_nettype none

package pbbc_pkg;

    localparam int NUM_TYPES   = 6;
    localparam int LEN_W       = 31;
    localparam int POS_W       = 32;
    localparam int COUNT_W     = 17;
    localparam int DIV_STEPS   = 32;
    localparam int COUNT_FIELD = 131071;

    localparam logic [LEN_W-1:0] PERIOD_RESET = 31'd4194304;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_BOX_PERIOD = 3'd0;
    localparam logic [2:0] REG_TYPE_MASK  = 3'd1;
    localparam logic [2:0] REG_LEN_FIRST  = 3'd2;

    typedef struct packed {
        logic [2:0]              kind_of_bond;
        logic                    endpoints_found;
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic                    last_bond;
    } t_bond_in;

    typedef struct packed {
        logic [2:0]         updated_kind;
        logic               broke_now;
        logic [COUNT_W-1:0] broken_so_far;
        logic               pass_done;
    } t_bond_out;

    typedef struct packed {
        logic [LEN_W-1:0]                    box_period;
        logic [NUM_TYPES-1:0]                type_mask;
        logic [NUM_TYPES-1:0][LEN_W-1:0]     trip_len;
    } t_cfg;

    // classified bond handed from the front to the back
    typedef struct packed {
        logic [2:0]              kind;
        logic                    checked;
        logic                    last;
        logic [LEN_W-1:0]        len;
        logic signed [POS_W:0]   dx;
        logic signed [POS_W:0]   dy;
    } t_task;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FOLD,
        S_SQX,
        S_SQY,
        S_SQL,
        S_CMP,
        S_DONE
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/periodic_bond_break_check_core.sv =====
// top level of the periodic bond break check
//
//  channel   direction  handshake             transaction
//  bond in   input      push / full           one bond with both atom positions
//  result    output     empty / pop           updated type, break flag, pass count
//  config    input      psel/penable/pwrite   one register write or read
//
// an unchecked bond goes from load straight to the result register; a checked bond
// passes load, the remainder steps of the serial divider, fold, the shared squarer
// and compare, then the result register; a zero period skips the divide and fold
// steps, and the serial divider sets the rate unless the result register stalls
// reset is synchronous, active low, and clears control state and the configuration registers
// the two-entry queue and the result register let front and back stall on their own
`default_nettype none

module periodic_bond_break_check_core
    import pbbc_pkg::*;
#(
    parameter int unsigned MAX_BONDS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_bond_in    i_item,
    output logic             empty,
    input  wire logic        pop,
    output t_bond_out        o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg  cfg;
    t_task front_task;
    t_task back_task;
    logic  q_empty;
    logic  q_pop;

    pbbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pbbc_front u_front (
        .i_item (i_item),
        .i_cfg  (cfg),
        .o_task (front_task)
    );

    pbbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_task),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (back_task),
        .o_empty (q_empty)
    );

    pbbc_back #(
        .MAX_BONDS (MAX_BONDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_period  (cfg.box_period),
        .i_task    (back_task),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pbbc_regs.sv =====
// configuration register file behind the apb-style port
`default_nettype none

module pbbc_regs
    import pbbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;
    logic [2:0] len_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign idx     = paddr[4:2];
    assign len_idx = idx - REG_LEN_FIRST;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_period <= PERIOD_RESET;
            r_cfg.type_mask  <= '0;
            r_cfg.trip_len   <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_BOX_PERIOD: r_cfg.box_period <= pwdata[LEN_W-1:0];
                REG_TYPE_MASK:  r_cfg.type_mask  <= pwdata[NUM_TYPES-1:0];
                default:        r_cfg.trip_len[len_idx] <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BOX_PERIOD: prdata = {1'b0, r_cfg.box_period};
            REG_TYPE_MASK:  prdata = {26'd0, r_cfg.type_mask};
            default:        prdata = {1'b0, r_cfg.trip_len[len_idx]};
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pbbc_front.sv =====
// front end: classifies an incoming bond and forms its differences
`default_nettype none

module pbbc_front
    import pbbc_pkg::*;
(
    input  wire t_bond_in i_item,
    input  wire t_cfg     i_cfg,
    output t_task         o_task
);

    logic [7:0]       present;
    logic [LEN_W-1:0] len;

    // bit k of present stands for bond type k; types 0 and 1 never checked
    assign present = {i_cfg.type_mask, 2'b00};

    always_comb begin
        unique case (i_item.kind_of_bond)
            3'd2:    len = i_cfg.trip_len[0];
            3'd3:    len = i_cfg.trip_len[1];
            3'd4:    len = i_cfg.trip_len[2];
            3'd5:    len = i_cfg.trip_len[3];
            3'd6:    len = i_cfg.trip_len[4];
            3'd7:    len = i_cfg.trip_len[5];
            default: len = '0;
        endcase
    end

    always_comb begin
        o_task.kind    = i_item.kind_of_bond;
        o_task.checked = i_item.endpoints_found && present[i_item.kind_of_bond];
        o_task.last    = i_item.last_bond;
        o_task.len     = len;
        o_task.dx      = {i_item.first_x[POS_W-1], i_item.first_x}
                       - {i_item.second_x[POS_W-1], i_item.second_x};
        o_task.dy      = {i_item.first_y[POS_W-1], i_item.first_y}
                       - {i_item.second_y[POS_W-1], i_item.second_y};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pbbc_queue.sv =====
// two-entry queue between front and back
`default_nettype none

module pbbc_queue
    import pbbc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_task i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_task      o_data,
    output logic       o_empty
);

    t_task      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            if (do_push && !do_pop) begin
                r_level <= r_level + 2'd1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pbbc_back.sv =====
// back end: periodic fold, squared-length test, pass count and result register
`default_nettype none

module pbbc_back
    import pbbc_pkg::*;
#(
    parameter int unsigned MAX_BONDS = 65536
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [LEN_W-1:0] i_period,
    input  wire t_task      i_task,
    input  wire logic       i_q_empty,
    output logic            o_q_pop,
    output t_bond_out       o_result,
    output logic            o_empty,
    input  wire logic       i_pop
);

    localparam int unsigned CountField = COUNT_FIELD;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_BONDS < CountField) ? MAX_BONDS : CountField);

    t_back_state r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [POS_W-1:0]   r_a, n_a;
    logic [POS_W-1:0]   r_b, n_b;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [4:0]         r_cnt, n_cnt;
    logic [63:0]        r_prod, n_prod;
    logic [64:0]        r_acc, n_acc;
    logic [2:0]         r_kind, n_kind;
    logic               r_last, n_last;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_broke, n_broke;
    t_bond_out          r_out, n_out;

    logic               out_free;
    logic [POS_W:0]     neg_dx;
    logic [POS_W:0]     neg_dy;
    logic [POS_W-1:0]   abs_dx;
    logic [POS_W-1:0]   abs_dy;
    logic [31:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        rem_sub;
    logic [31:0]        rem_x2;
    logic [LEN_W-1:0]   fold_hi;
    logic [31:0]        mul_op;
    logic [63:0]        square;
    logic [COUNT_W-1:0] count_inc;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    assign neg_dx = (POS_W+1)'(0) - i_task.dx;
    assign neg_dy = (POS_W+1)'(0) - i_task.dy;
    assign abs_dx = i_task.dx[POS_W] ? neg_dx[POS_W-1:0] : i_task.dx[POS_W-1:0];
    assign abs_dy = i_task.dy[POS_W] ? neg_dy[POS_W-1:0] : i_task.dy[POS_W-1:0];

    // restoring division step, only the remainder is kept
    assign rem_sh  = {r_rem, r_a[POS_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, i_period};
    assign rem_sub = rem_sh - {1'b0, i_period};

    // nearest image: the remainder or its distance to the next period
    assign rem_x2  = {r_rem, 1'b0};
    assign fold_hi = i_period - r_rem;

    assign square = mul_op * mul_op;

    assign count_inc = (r_count < COUNT_LIMIT) ? r_count + COUNT_W'(1) : r_count;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_count     = r_count;
        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_kind      = r_kind;
        n_last      = r_last;
        n_len       = r_len;
        n_broke     = r_broke;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        mul_op      = r_a;

        if (i_pop && r_out_valid) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_a     = abs_dx;
                    n_b     = abs_dy;
                    n_kind  = i_task.kind;
                    n_last  = i_task.last;
                    n_len   = i_task.len;
                    n_broke = 1'b0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    priority if (!i_task.checked) begin
                        n_state = S_DONE;
                    end else if (i_period == '0) begin
                        n_state = S_SQX;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                n_a   = {r_a[POS_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS-1)) n_state = S_FOLD;
            end
            S_FOLD: begin
                n_a     = (rem_x2 >= {1'b0, i_period}) ? {1'b0, fold_hi} : {1'b0, r_rem};
                n_state = S_SQX;
            end
            S_SQX: begin
                mul_op  = r_a;
                n_prod  = square;
                n_state = S_SQY;
            end
            S_SQY: begin
                mul_op  = r_b;
                n_acc   = {1'b0, r_prod};
                n_prod  = square;
                n_state = S_SQL;
            end
            S_SQL: begin
                mul_op  = {1'b0, r_len};
                n_acc   = r_acc + {1'b0, r_prod};
                n_prod  = square;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_broke = r_acc > {1'b0, r_prod};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.updated_kind  = r_broke ? 3'd0 : r_kind;
                    n_out.broke_now     = r_broke;
                    n_out.broken_so_far = r_broke ? count_inc : r_count;
                    n_out.pass_done     = r_last;
                    n_out_valid         = 1'b1;
                    // the pass count restarts after the bond marked last
                    n_count             = r_last ? '0 : (r_broke ? count_inc : r_count);
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_kind  <= n_kind;
        r_last  <= n_last;
        r_len   <= n_len;
        r_broke <= n_broke;
        r_out   <= n_out;
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_LIMIT)
        else $error("pass count above its limit");

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (r_rem < i_period))
        else $error("division remainder not below period");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_FOLD))
        else $error("divider left early");

    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_last) |=> (r_count == '0))
        else $error("pass count not cleared after last bond");

endmodule

`default_nettype wire
